>>> sv/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg: shared definitions for the stereo linear resampler
// Widths, count limits, register indexes, payload and control structs, and
// the controller state type used by the resampler modules.
// ----------------------------------------------------------------------------
package slr_pkg;

	// Sample and count widths.
	localparam int SAMPLE_W  = 16;
	localparam int CNT_W     = 13;
	localparam int CFG_IDX_W = 2;

	// Largest block length and largest number of outputs per input frame.
	localparam int MAX_BLOCK = 4096;
	localparam int MAX_RUN   = 64;

	// Register values after reset.
	localparam int OLD_COUNT_RESET = 2;
	localparam int NEW_COUNT_RESET = 3;

	// Magnitude of a weighted sum stays below 2^15 * 2^13.
	localparam int DIV_W = SAMPLE_W - 1 + CNT_W;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0]           count_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

	// Register indexes of the configuration port.
	localparam cfg_idx_t REG_OLD_COUNT = 2'd0;
	localparam cfg_idx_t REG_NEW_COUNT = 2'd1;

	typedef struct packed {
		sample_t left_in;
		sample_t right_in;
	} in_frame_t;

	typedef struct packed {
		sample_t left_out;
		sample_t right_out;
		logic    run_last;
		logic    block_end;
	} out_frame_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic mul;
		logic start_div;
		logic emit;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic run_ok;
		logic div_done;
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} ctrl_state_t;

endpackage

>>> sv/slr_div.sv
// ----------------------------------------------------------------------------
// slr_div: serial unsigned divider
// Restoring division, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module slr_div #(
	parameter int DW = slr_pkg::DIV_W,
	parameter int VW = slr_pkg::CNT_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;
	logic [VW-1:0] rem_next;

	// One restoring step: bring down the next dividend bit and try a subtract.
	always_comb begin
		trial    = {rem_q, dvd_q[DW-1]};
		diff     = trial - {1'b0, dsr_q};
		ge       = (trial >= {1'b0, dsr_q});
		rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Operand registers; quotient bits shift in behind the dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

>>> sv/slr_ctrl.sv
// ----------------------------------------------------------------------------
// slr_ctrl: resampler controller
// Sequences one input frame through its outputs: check for a due output,
// multiply, divide, present the result, and close the frame.
// ----------------------------------------------------------------------------
module slr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  slr_pkg::status_t status,
	output slr_pkg::cmd_t    cmd
);
	import slr_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_next = status.run_ok ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				state_next = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_next = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					state_next = ST_CHECK;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_CHECK: begin
				cmd.mul    = status.run_ok;
				cmd.finish = !status.run_ok;
			end
			ST_MUL: begin
				cmd.start_div = 1'b1;
			end
			ST_DIV: begin
				cmd.emit = status.div_done;
			end
			ST_OUT: begin
				out_valid = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> sv/slr_datapath.sv
// ----------------------------------------------------------------------------
// slr_datapath: resampler datapath
// Holds the configuration, the block position state and the frame samples,
// forms the weighted sums, divides them and the next output position, and
// keeps the output register.
// ----------------------------------------------------------------------------
module slr_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  slr_pkg::cfg_idx_t  cfg_index,
	input  slr_pkg::count_t    cfg_data,
	input  slr_pkg::in_frame_t in_data,
	input  slr_pkg::cmd_t      cmd,
	output slr_pkg::status_t   status,
	output slr_pkg::out_frame_t out_data
);
	import slr_pkg::*;

	localparam int PROD_W = SAMPLE_W + CNT_W + 1;

	// Configuration and block state.
	count_t  old_q;
	count_t  new_q;
	sample_t prev_l_q;
	sample_t prev_r_q;
	count_t  frame_idx_q;
	count_t  out_idx_q;
	count_t  pos_q;
	count_t  rem_q;

	// Payload registers.
	sample_t                   cur_l_q;
	sample_t                   cur_r_q;
	logic signed [PROD_W-1:0]  prod_la_s1;
	logic signed [PROD_W-1:0]  prod_lb_s1;
	logic signed [PROD_W-1:0]  prod_ra_s1;
	logic signed [PROD_W-1:0]  prod_rb_s1;
	logic [2*CNT_W-1:0]        pos_prod_s1;
	logic                      neg_l_q;
	logic                      neg_r_q;
	out_frame_t                out_q;

	// Effective counts and helpers.
	count_t       old_nz;
	count_t       new_nz;
	count_t       o_eff;
	count_t       n_eff;
	logic [31:0]  lim;
	count_t       next_idx;
	count_t       wgt_a;
	logic signed [PROD_W:0] sum_l;
	logic signed [PROD_W:0] sum_r;
	logic [PROD_W:0]        abs_l;
	logic [PROD_W:0]        abs_r;
	logic [DIV_W-1:0]       dvd_p;
	logic [DIV_W-1:0]       val_l;
	logic [DIV_W-1:0]       val_r;
	logic                   cfg_hit;
	logic                   block_wrap;

	// Divider results.
	logic             done_l;
	logic             done_r;
	logic             done_p;
	logic [DIV_W-1:0] quot_l;
	logic [DIV_W-1:0] quot_r;
	logic [DIV_W-1:0] quot_p;
	count_t           rem_l;
	count_t           rem_r;
	count_t           rem_p;

	// Clamp the register values to the counts actually used.
	always_comb begin
		old_nz = (old_q == '0) ? count_t'(1) : old_q;
		o_eff  = (32'(old_nz) > 32'(MAX_BLOCK)) ? count_t'(MAX_BLOCK) : old_nz;
		lim    = 32'(MAX_RUN) * 32'(o_eff);
		if (lim > 32'(MAX_BLOCK)) begin
			lim = 32'(MAX_BLOCK);
		end
		new_nz = (new_q == '0) ? count_t'(1) : new_q;
		n_eff  = (32'(new_nz) > lim) ? count_t'(lim) : new_nz;
	end

	// Weights, sums and signed results.
	always_comb begin
		next_idx = out_idx_q + count_t'(1);
		wgt_a    = n_eff - rem_q;
		sum_l    = {prod_la_s1[PROD_W-1], prod_la_s1} + {prod_lb_s1[PROD_W-1], prod_lb_s1};
		sum_r    = {prod_ra_s1[PROD_W-1], prod_ra_s1} + {prod_rb_s1[PROD_W-1], prod_rb_s1};
		abs_l    = sum_l[PROD_W] ? -sum_l : sum_l;
		abs_r    = sum_r[PROD_W] ? -sum_r : sum_r;
		dvd_p    = DIV_W'(pos_prod_s1);
		val_l    = neg_l_q ? -quot_l : quot_l;
		val_r    = neg_r_q ? -quot_r : quot_r;
		cfg_hit  = cfg_write && ((cfg_index == REG_OLD_COUNT) || (cfg_index == REG_NEW_COUNT));
		block_wrap = ((32'(frame_idx_q) + 32'd1) >= 32'(o_eff));
	end

	// An output is due while the block has outputs left and the next one
	// falls on the current frame.
	assign status.run_ok   = (out_idx_q < n_eff) && (pos_q == frame_idx_q);
	assign status.div_done = done_l && done_r && done_p;

	// Configuration, block position and previous frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_q       <= count_t'(OLD_COUNT_RESET);
			new_q       <= count_t'(NEW_COUNT_RESET);
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			frame_idx_q <= '0;
			out_idx_q   <= '0;
			pos_q       <= '0;
			rem_q       <= '0;
		end else begin
			if (cmd.emit) begin
				out_idx_q <= next_idx;
				if (next_idx < n_eff) begin
					pos_q <= quot_p[CNT_W-1:0];
					rem_q <= rem_p;
				end
			end
			if (cmd.finish) begin
				prev_l_q <= cur_l_q;
				prev_r_q <= cur_r_q;
				if (block_wrap) begin
					frame_idx_q <= '0;
					out_idx_q   <= '0;
					pos_q       <= '0;
					rem_q       <= '0;
				end else begin
					frame_idx_q <= frame_idx_q + count_t'(1);
				end
			end
			// Any valid register write restarts the block.
			if (cfg_hit) begin
				if (cfg_index == REG_OLD_COUNT) begin
					old_q <= cfg_data;
				end else begin
					new_q <= cfg_data;
				end
				frame_idx_q <= '0;
				out_idx_q   <= '0;
				pos_q       <= '0;
				rem_q       <= '0;
			end
		end
	end

	// Sample capture, products, sign flags and the output register.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cur_l_q <= in_data.left_in;
			cur_r_q <= in_data.right_in;
		end
		if (cmd.mul) begin
			prod_la_s1  <= prev_l_q * $signed({1'b0, wgt_a});
			prod_lb_s1  <= cur_l_q * $signed({1'b0, rem_q});
			prod_ra_s1  <= prev_r_q * $signed({1'b0, wgt_a});
			prod_rb_s1  <= cur_r_q * $signed({1'b0, rem_q});
			pos_prod_s1 <= {{CNT_W{1'b0}}, next_idx} * {{CNT_W{1'b0}}, o_eff};
		end
		if (cmd.start_div) begin
			neg_l_q <= sum_l[PROD_W];
			neg_r_q <= sum_r[PROD_W];
		end
		if (cmd.emit) begin
			out_q.left_out  <= val_l[SAMPLE_W-1:0];
			out_q.right_out <= val_r[SAMPLE_W-1:0];
			out_q.run_last  <= !((next_idx < n_eff) && (quot_p[CNT_W-1:0] == frame_idx_q));
			out_q.block_end <= (next_idx == n_eff);
		end
	end

	assign out_data = out_q;

	// Left, right and position dividers run side by side.
	slr_div #(.DW(DIV_W), .VW(CNT_W)) u_div_l (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start_div),
		.dividend  (abs_l[DIV_W-1:0]),
		.divisor   (n_eff),
		.done      (done_l),
		.quotient  (quot_l),
		.remainder (rem_l)
	);

	slr_div #(.DW(DIV_W), .VW(CNT_W)) u_div_r (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start_div),
		.dividend  (abs_r[DIV_W-1:0]),
		.divisor   (n_eff),
		.done      (done_r),
		.quotient  (quot_r),
		.remainder (rem_r)
	);

	slr_div #(.DW(DIV_W), .VW(CNT_W)) u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start_div),
		.dividend  (dvd_p),
		.divisor   (n_eff),
		.done      (done_p),
		.quotient  (quot_p),
		.remainder (rem_p)
	);

endmodule

>>> sv/stereo_linear_resampler_top.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top: stereo linear-interpolation resampler
// Takes 16-bit stereo frames in blocks of old_count and emits new_count
// interpolated frames per block, each as soon as the frame it needs has
// arrived. Frames are handled one at a time: each output that a frame yields
// passes through the bit-serial dividers (28 steps) that divide both weighted
// sums and the next output position by new_count, and then waits to be taken
// before the next output or frame is started. Register writes restart the
// block and must only be made while no frame is in flight.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  slr_pkg::cfg_idx_t   cfg_index,
	input  slr_pkg::count_t     cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  slr_pkg::in_frame_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output slr_pkg::out_frame_t out_data
);
	import slr_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencing.
	slr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Arithmetic and state.
	slr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

>>> sv/slr_checker.sv
// ----------------------------------------------------------------------------
// slr_checker: port-level checks for the resampler
// Watches the top-level handshakes and output flags over time.
// ----------------------------------------------------------------------------
module slr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input slr_pkg::out_frame_t out_data
);
	import slr_pkg::*;

	// A stalled result stays presented and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// The block never takes a frame while a result is waiting.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result is pending");

	// A result never appears in the cycle right after a frame transfer.
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result shown directly after input transfer");

	// The last output of a block is also the last one of its frame.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.block_end |-> out_data.run_last)
		else $error("block end without run end");

endmodule

bind stereo_linear_resampler_top slr_checker u_slr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> tb/sv/stereo_linear_resampler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top_tb: self-checking bench for the stereo resampler
// Sends stereo frames over a valid/ready channel and predicts every
// interpolated output frame with a behavioral copy of the resampler. A
// checker compares each output transfer, field by field, against the oldest
// prediction. Directed tests cover the reset counts, zero and oversized
// counts, frames that yield nothing and block restarts. A random stream then
// sweeps many count settings while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module stereo_linear_resampler_top_tb;
	import slr_pkg::*;

	localparam int RANDOM_FRAMES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam sample_t SAMPLE_MAX = 16'sh7fff;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	// Register indexes that the block does not implement.
	localparam cfg_idx_t REG_SPARE_A = 2'd2;
	localparam cfg_idx_t REG_SPARE_B = 2'd3;

	// Receiver stall behaviors.
	typedef enum int {RX_FREE, RX_COIN, RX_MASK, RX_SPARSE} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	cfg_idx_t   cfg_index = REG_OLD_COUNT;
	count_t     cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_frame_t  in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_frame_t out_data;

	// Behavioral state of the resampler.
	count_t      reg_old = count_t'(OLD_COUNT_RESET);
	count_t      reg_new = count_t'(NEW_COUNT_RESET);
	sample_t     last_left = '0;
	sample_t     last_right = '0;
	logic [11:0] frame_idx = '0;
	logic [12:0] out_idx = '0;
	logic [11:0] next_pos = '0;
	logic [11:0] next_rem = '0;

	// Predicted output frames, oldest first.
	out_frame_t resampled_q[$];

	int       mismatch_count = 0;
	bit       gaps_on = 1'b1;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int       rx_left = 0;
	logic [7:0] rx_mask = 8'hff;
	int       rx_pos = 0;
	out_frame_t want;

	stereo_linear_resampler_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 250 MHz clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Weighted blend of two samples, truncated toward zero.
	function automatic sample_t interp(sample_t a, sample_t b, int unsigned r,
			int unsigned n);
		longint acc;
		acc = longint'(a) * longint'(n - r) + longint'(b) * longint'(r);
		return sample_t'(acc / longint'(n));
	endfunction

	task automatic restart_block();
		frame_idx = '0;
		out_idx = '0;
		next_pos = '0;
		next_rem = '0;
	endtask

	// Work out the output frames caused by one accepted input frame.
	task automatic resample_frame(in_frame_t f);
		int unsigned o, n, cap, io;
		int cnt;
		out_frame_t r;
		o = (reg_old == 0) ? 1 : reg_old;
		if (o > MAX_BLOCK) o = MAX_BLOCK;
		cap = MAX_RUN * o;
		if (cap > MAX_BLOCK) cap = MAX_BLOCK;
		n = (reg_new == 0) ? 1 : reg_new;
		if (n > cap) n = cap;
		cnt = 0;
		while (out_idx < n && next_pos == frame_idx && cnt < MAX_RUN) begin
			r.left_out = interp(last_left, f.left_in, next_rem, n);
			r.right_out = interp(last_right, f.right_in, next_rem, n);
			r.run_last = 1'b0;
			r.block_end = (out_idx == n - 1);
			resampled_q.push_back(r);
			cnt++;
			out_idx++;
			if (out_idx < n) begin
				io = out_idx * o;
				next_pos = 12'(io / n);
				next_rem = 12'(io % n);
			end
		end
		// The last frame of this run carries the run marker.
		if (cnt > 0) begin
			r = resampled_q.pop_back();
			r.run_last = 1'b1;
			resampled_q.push_back(r);
		end
		last_left = f.left_in;
		last_right = f.right_in;
		if (frame_idx + 1 >= o)
			restart_block();
		else
			frame_idx++;
	endtask

	// Register write; called at a falling edge while the block is idle.
	task automatic write_reg(cfg_idx_t idx, count_t value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		if (idx == REG_OLD_COUNT) begin
			reg_old = value;
			restart_block();
		end else if (idx == REG_NEW_COUNT) begin
			reg_new = value;
			restart_block();
		end
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// One input transfer, with bursts and gaps on the sending side.
	task automatic send_frame(sample_t left, sample_t right);
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		in_data <= '{left_in: left, right_in: right};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		resample_frame(in_data);
		@(negedge clk);
		if (burst_left > 0) burst_left--;
	endtask

	// Hold off input until every predicted frame has been taken.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (resampled_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sample values biased toward the extremes and small magnitudes.
	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(-int'($urandom_range(0, 1)));
			3, 4: return sample_t'(int'($urandom_range(0, 127)) - 64);
			default: return sample_t'($urandom());
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_frame(SAMPLE_MAX, SAMPLE_MIN);
		send_frame(SAMPLE_MIN, SAMPLE_MAX);
		send_frame(sample_t'(0), sample_t'(-1));
		send_frame(sample_t'(-1), sample_t'(1));
		send_frame(sample_t'(-12345), sample_t'(321));
		drain_block();
	endtask

	// A count of zero behaves as one.
	task automatic test_zero_counts();
		write_reg(REG_OLD_COUNT, '0);
		write_reg(REG_NEW_COUNT, '0);
		send_frame(sample_t'(-7), sample_t'(7));
		send_frame(SAMPLE_MIN, sample_t'(0));
		send_frame(sample_t'(0), SAMPLE_MAX);
		drain_block();
	endtask

	// Downsampling leaves several frames of the block without output.
	task automatic test_no_output_frames();
		write_reg(REG_OLD_COUNT, count_t'(5));
		write_reg(REG_NEW_COUNT, count_t'(2));
		repeat (5) send_frame(rand_sample(), rand_sample());
		drain_block();
	endtask

	// Writes to real registers restart the block; spare indexes do not.
	task automatic test_block_restart();
		write_reg(REG_OLD_COUNT, count_t'(3));
		write_reg(REG_NEW_COUNT, count_t'(4));
		repeat (2) send_frame(rand_sample(), rand_sample());
		drain_block();
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '0);
		repeat (2) send_frame(rand_sample(), rand_sample());
		drain_block();
		write_reg(REG_OLD_COUNT, count_t'(3));
		repeat (2) send_frame(rand_sample(), rand_sample());
		drain_block();
	endtask

	// Oversized counts are clamped to the block and run limits.
	task automatic test_count_limits();
		write_reg(REG_OLD_COUNT, count_t'(1));
		write_reg(REG_NEW_COUNT, '1);
		repeat (2) send_frame(rand_sample(), rand_sample());
		drain_block();
		write_reg(REG_OLD_COUNT, '1);
		repeat (2) send_frame(rand_sample(), rand_sample());
		drain_block();
		write_reg(REG_OLD_COUNT, count_t'(MAX_BLOCK));
		write_reg(REG_NEW_COUNT, count_t'(1));
		repeat (2) send_frame(rand_sample(), rand_sample());
		drain_block();
	endtask

	// Random count settings, each followed by a stream of random frames.
	task automatic test_random_stream();
		int unsigned sent, frames, kind;
		count_t o_val, n_val;
		sent = 0;
		while (sent < RANDOM_FRAMES) begin
			kind = $urandom_range(0, 19);
			gaps_on = ($urandom_range(0, 3) != 0);
			if (kind < 14) begin
				o_val = count_t'($urandom_range(0, 8));
				n_val = count_t'($urandom_range(0, 16));
				frames = $urandom_range(1, 30);
			end else if (kind < 17) begin
				o_val = count_t'($urandom_range(9, 300));
				n_val = count_t'($urandom_range(1, 300));
				frames = $urandom_range(1, 30);
			end else if (kind < 19) begin
				o_val = count_t'($urandom_range(0, 8191));
				n_val = count_t'($urandom_range(0, 8191));
				frames = $urandom_range(1, 8);
			end else begin
				// Dense upsampling: up to a full run per frame.
				o_val = count_t'($urandom_range(1, 2));
				n_val = count_t'($urandom_range(64, 8191));
				frames = $urandom_range(1, 4);
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_OLD_COUNT, o_val);
			write_reg(REG_NEW_COUNT, n_val);
			if ($urandom_range(0, 9) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					count_t'($urandom()));
			repeat (frames) begin
				if ($urandom_range(0, 49) == 0)
					drain_block();
				send_frame(rand_sample(), rand_sample());
				sent++;
			end
			drain_block();
		end
	endtask

	// Receiver stall pattern, switching to a random behavior when its countdown runs out.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 200);
			rx_mask = 8'($urandom_range(1, 255));
		end else begin
			rx_left--;
		end
		rx_pos = (rx_pos + 1) % 8;
		case (rx_mode)
			RX_FREE: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_MASK: out_ready <= rx_mask[rx_pos];
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic bit field_ok(string name, int exp_val, int act_val);
		if (exp_val == act_val) return 1'b1;
		$display("%0t: %s mismatch, expected %0d, actual %0d",
			$time, name, exp_val, act_val);
		return 1'b0;
	endfunction

	// Check every output transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (resampled_q.size() == 0) begin
				$display("%0t: unexpected output, expected none, actual %0d %0d %0b %0b",
					$time, out_data.left_out, out_data.right_out,
					out_data.run_last, out_data.block_end);
				mismatch_count++;
			end else begin
				want = resampled_q.pop_front();
				if (!field_ok("left_out", want.left_out, out_data.left_out)
						| !field_ok("right_out", want.right_out, out_data.right_out)
						| !field_ok("run_last", want.run_last, out_data.run_last)
						| !field_ok("block_end", want.block_end, out_data.block_end))
					mismatch_count++;
			end
		end
	end

	// Timeout.
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_zero_counts();
		test_no_output_frames();
		test_block_restart();
		test_count_limits();
		test_random_stream();
		drain_block();
		if (mismatch_count == 0 && resampled_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
